@@ design/mhpq_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mhpq_pkg - shared types and constants for the min-heap priority queue
// Sizes of the heap store, entry layout, operation and status codes.
// ----------------------------------------------------------------------------
package mhpq_pkg;

  // Heap sizing
  localparam int CAPACITY   = 256;
  localparam int KEY_BITS   = 32;
  localparam int TAG_BITS   = 9;
  localparam int COUNT_BITS = $clog2(CAPACITY + 1);
  localparam int ADDR_BITS  = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

  typedef logic [KEY_BITS-1:0]   key_t;
  typedef logic [TAG_BITS-1:0]   tag_t;
  typedef logic [COUNT_BITS-1:0] slot_t;   // 1-based slot number or fill count
  typedef logic [COUNT_BITS:0]   child_t;  // child slot number, one bit wider
  typedef logic [ADDR_BITS-1:0]  addr_t;   // RAM address, slot minus one

  typedef struct packed {
    key_t key;
    tag_t tag;
  } entry_t;

  typedef enum logic {
    OP_PUSH = 1'b0,
    OP_POP  = 1'b1
  } opcode_t;

  typedef enum logic [1:0] {
    STATUS_OK    = 2'd0,
    STATUS_EMPTY = 2'd1,
    STATUS_FULL  = 2'd2
  } status_t;

  // Slot number to RAM address
  function automatic addr_t slot_addr(input slot_t slot);
    slot_t diff;
    diff = slot - slot_t'(1);
    return diff[ADDR_BITS-1:0];
  endfunction

  // Child slot number to RAM address
  function automatic addr_t child_addr(input child_t slot);
    child_t diff;
    diff = slot - child_t'(1);
    return diff[ADDR_BITS-1:0];
  endfunction

endpackage

@@ design/mhpq_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mhpq_if - request and response channels of the min-heap priority queue
// Valid/ready channels; a transfer happens when valid and ready are both high.
// ----------------------------------------------------------------------------
interface mhpq_cmd_if;
  import mhpq_pkg::*;

  logic              valid;
  logic              ready;
  opcode_t           opcode;
  key_t              item_key;
  tag_t              item_tag;

  modport source (output valid, output opcode, output item_key, output item_tag,
                  input ready);
  modport sink   (input valid, input opcode, input item_key, input item_tag,
                  output ready);
endinterface

interface mhpq_rsp_if;
  import mhpq_pkg::*;

  logic              valid;
  logic              ready;
  logic              popped_valid;
  key_t              popped_key;
  tag_t              popped_tag;
  status_t           status;
  slot_t             occupancy;

  modport source (output valid, output popped_valid, output popped_key,
                  output popped_tag, output status, output occupancy,
                  input ready);
  modport sink   (input valid, input popped_valid, input popped_key,
                  input popped_tag, input status, input occupancy,
                  output ready);
endinterface

@@ design/min_heap_priority_queue.sv @@
`timescale 1ns / 1ps
// Push climbs from the new last slot until its parent is not larger or it reaches the
// root; pop takes the root and sifts the last entry down until no child is smaller or
// it reaches a slot with no children. A push on a full heap or a pop on an empty one
// goes straight to the finish state. A response stall holds the finish state.
// One operation at a time: the next command is taken once the result loads.
// Reset (rst, synchronous) empties the heap.
// ----------------------------------------------------------------------------
// min_heap_priority_queue - binary min-heap of key and tag pairs
// Push sifts the new entry up, pop returns the root and sifts the last entry
// down, one level per read state and compare state, through the heap RAM.
// ----------------------------------------------------------------------------
module min_heap_priority_queue (
  input  logic      clk,
  input  logic      rst,
  mhpq_cmd_if.sink  cmd,
  mhpq_rsp_if.source rsp
);
  import mhpq_pkg::*;

  typedef enum logic [6:0] {
    S_IDLE   = 7'b0000001,
    S_UP_RD  = 7'b0000010,
    S_UP_CMP = 7'b0000100,
    S_POP_RD = 7'b0001000,
    S_DN_RD  = 7'b0010000,
    S_DN_CMP = 7'b0100000,
    S_FINISH = 7'b1000000
  } state_t;

  state_t  state, state_next;
  slot_t   count, count_next;
  slot_t   pos, pos_next;
  entry_t  moving, moving_next;
  logic    res_popped, res_popped_next;
  key_t    res_key, res_key_next;
  tag_t    res_tag, res_tag_next;
  status_t res_status, res_status_next;

  // Output register
  logic    out_valid;
  logic    out_popped;
  key_t    out_key;
  tag_t    out_tag;
  status_t out_status;
  slot_t   out_occ;

  // Heap RAM ports
  logic    ram_we;
  addr_t   ram_waddr;
  entry_t  ram_wdata;
  addr_t   ram_raddr_a;
  addr_t   ram_raddr_b;
  entry_t  ram_rdata_a;
  entry_t  ram_rdata_b;

  // Tree navigation
  slot_t   parent;
  child_t  left, right;
  logic    left_ok, right_ok;
  logic    left_lt, right_lt;
  key_t    best_key;

  assign parent   = pos >> 1;
  assign left     = {pos, 1'b0};
  assign right    = left + child_t'(1);
  assign left_ok  = left <= {1'b0, count};
  assign right_ok = right <= {1'b0, count};

  // Down-sift compare: left child first, then right against the best so far
  assign left_lt  = ram_rdata_a.key < moving.key;
  assign best_key = left_lt ? ram_rdata_a.key : moving.key;
  assign right_lt = right_ok && (ram_rdata_b.key < best_key);

  assign cmd.ready = (state == S_IDLE) && !rst;

  // Sequencer
  always_comb begin
    state_next      = state;
    count_next      = count;
    pos_next        = pos;
    moving_next     = moving;
    res_popped_next = res_popped;
    res_key_next    = res_key;
    res_tag_next    = res_tag;
    res_status_next = res_status;
    ram_we          = 1'b0;
    ram_waddr       = slot_addr(pos);
    ram_wdata       = moving;
    ram_raddr_a     = slot_addr(parent);
    ram_raddr_b     = slot_addr(count);

    unique case (state)
      S_IDLE: begin
        if (cmd.valid) begin
          res_popped_next = 1'b0;
          res_key_next    = '0;
          res_tag_next    = '0;
          res_status_next = STATUS_OK;
          if (cmd.opcode == OP_PUSH) begin
            if (count == slot_t'(CAPACITY)) begin
              res_status_next = STATUS_FULL;
              state_next      = S_FINISH;
            end else begin
              count_next      = count + slot_t'(1);
              pos_next        = count + slot_t'(1);
              moving_next.key = cmd.item_key;
              moving_next.tag = cmd.item_tag;
              state_next      = S_UP_RD;
            end
          end else begin
            if (count == '0) begin
              res_status_next = STATUS_EMPTY;
              state_next      = S_FINISH;
            end else begin
              // read root on port A, last entry on port B
              ram_raddr_a = slot_addr(slot_t'(1));
              ram_raddr_b = slot_addr(count);
              state_next  = S_POP_RD;
            end
          end
        end
      end

      S_UP_RD: begin
        if (pos == slot_t'(1)) begin
          ram_we     = 1'b1;
          state_next = S_FINISH;
        end else begin
          ram_raddr_a = slot_addr(parent);
          state_next  = S_UP_CMP;
        end
      end

      S_UP_CMP: begin
        ram_we = 1'b1;
        if (moving.key < ram_rdata_a.key) begin
          // parent moves down into the hole
          ram_wdata  = ram_rdata_a;
          pos_next   = parent;
          state_next = S_UP_RD;
        end else begin
          state_next = S_FINISH;
        end
      end

      S_POP_RD: begin
        res_popped_next = 1'b1;
        res_key_next    = ram_rdata_a.key;
        res_tag_next    = ram_rdata_a.tag;
        moving_next     = ram_rdata_b;
        count_next      = count - slot_t'(1);
        pos_next        = slot_t'(1);
        state_next      = S_DN_RD;
      end

      S_DN_RD: begin
        if (!left_ok) begin
          ram_we     = 1'b1;
          state_next = S_FINISH;
        end else begin
          ram_raddr_a = child_addr(left);
          ram_raddr_b = child_addr(right);
          state_next  = S_DN_CMP;
        end
      end

      S_DN_CMP: begin
        ram_we = 1'b1;
        if (right_lt) begin
          ram_wdata  = ram_rdata_b;
          pos_next   = right[COUNT_BITS-1:0];
          state_next = S_DN_RD;
        end else if (left_lt) begin
          ram_wdata  = ram_rdata_a;
          pos_next   = left[COUNT_BITS-1:0];
          state_next = S_DN_RD;
        end else begin
          state_next = S_FINISH;
        end
      end

      S_FINISH: begin
        if (!out_valid || rsp.ready) begin
          state_next = S_IDLE;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
    end else begin
      state <= state_next;
      count <= count_next;
    end
  end

  // Working registers
  always_ff @(posedge clk) begin
    pos        <= pos_next;
    moving     <= moving_next;
    res_popped <= res_popped_next;
    res_key    <= res_key_next;
    res_tag    <= res_tag_next;
    res_status <= res_status_next;
  end

  // Result register, loaded when the previous result has been taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == S_FINISH && (!out_valid || rsp.ready)) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_FINISH && (!out_valid || rsp.ready)) begin
      out_popped <= res_popped;
      out_key    <= res_key;
      out_tag    <= res_tag;
      out_status <= res_status;
      out_occ    <= count;
    end
  end

  assign rsp.valid        = out_valid;
  assign rsp.popped_valid = out_popped;
  assign rsp.popped_key   = out_key;
  assign rsp.popped_tag   = out_tag;
  assign rsp.status       = out_status;
  assign rsp.occupancy    = out_occ;

  // Heap store
  mhpq_ram #(
    .WIDTH ($bits(entry_t)),
    .DEPTH (CAPACITY)
  ) u_heap_ram (
    .clk     (clk),
    .we      (ram_we),
    .waddr   (ram_waddr),
    .wdata   (ram_wdata),
    .raddr_a (ram_raddr_a),
    .raddr_b (ram_raddr_b),
    .rdata_a (ram_rdata_a),
    .rdata_b (ram_rdata_b)
  );

endmodule

@@ design/mhpq_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mhpq_ram - generic RAM, one write port and two registered read ports
// Contents are undefined until written.
// ----------------------------------------------------------------------------
module mhpq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                       clk,
  input  logic                                       we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                           wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_a,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_b,
  output logic [WIDTH-1:0]                           rdata_a,
  output logic [WIDTH-1:0]                           rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read ports
  always_ff @(posedge clk) begin
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule
